// File: hw/rtl/fbsc_pkg.sv
// Shared types and constants of the frustum box and sphere culler.
`timescale 1ns / 1ps

package fbsc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_W     = 16;
  localparam int EXT_W       = 15;
  localparam int FRAC_W      = 14;
  localparam int REG_W       = 64;
  localparam int INDEX_W     = 3;
  localparam int PROD_W      = 2 * COORD_W;       // signed n * c
  localparam int MAG_W       = COORD_W + EXT_W;   // unsigned |n| * h
  localparam int DIST_W      = PROD_W + 2;        // three products plus offset
  localparam int RAD_W       = MAG_W + 2;         // three magnitudes
  localparam int EDGE_W      = DIST_W + 1;        // dist +/- radius

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_FAR    = 3'd1;
  localparam logic [INDEX_W-1:0] REG_LEFT   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_RIGHT  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_TOP    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_BOTTOM = 3'd5;

  // Planes that skip_depth leaves out: near and far
  localparam logic [PLANE_COUNT-1:0] DEPTH_MASK = 6'b000011;

  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  typedef enum logic [1:0] {
    CLS_OUTSIDE    = 2'd0,
    CLS_INTERSECTS = 2'd1,
    CLS_INSIDE     = 2'd2
  } cls_t;

  typedef enum logic {
    FUNC_BOX    = 1'b0,
    FUNC_SPHERE = 1'b1
  } func_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

endpackage

// File: hw/rtl/fbsc_item_if.sv
// Input channel: one bounding volume per word.
`timescale 1ns / 1ps

interface fbsc_item_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [fbsc_pkg::COORD_W-1:0] center_x;
  logic signed [fbsc_pkg::COORD_W-1:0] center_y;
  logic signed [fbsc_pkg::COORD_W-1:0] center_z;
  logic        [fbsc_pkg::EXT_W-1:0]   half_x;
  logic        [fbsc_pkg::EXT_W-1:0]   half_y;
  logic        [fbsc_pkg::EXT_W-1:0]   half_z;
  logic        [fbsc_pkg::EXT_W-1:0]   sphere_radius;
  logic                                skip_depth;

  modport source (
    output valid, func, center_x, center_y, center_z,
           half_x, half_y, half_z, sphere_radius, skip_depth,
    input  ready
  );
  modport sink (
    input  valid, func, center_x, center_y, center_z,
           half_x, half_y, half_z, sphere_radius, skip_depth,
    output ready
  );
endinterface

// File: hw/rtl/fbsc_result_if.sv
// Output channel: one classification per word.
`timescale 1ns / 1ps

interface fbsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] classification;
  logic       visible;

  modport source (output valid, classification, visible, input ready);
  modport sink (input valid, classification, visible, output ready);
endinterface

// File: hw/rtl/fbsc_plane.sv
// One plane lane: products, distance and radius sums, sign tests.
`timescale 1ns / 1ps

module fbsc_plane (
  input  logic                                clk,
  input  fbsc_pkg::stage_en_t                 en,
  input  fbsc_pkg::plane_t                    plane,
  input  logic signed [fbsc_pkg::COORD_W-1:0] center_x,
  input  logic signed [fbsc_pkg::COORD_W-1:0] center_y,
  input  logic signed [fbsc_pkg::COORD_W-1:0] center_z,
  input  logic        [fbsc_pkg::EXT_W-1:0]   half_x,
  input  logic        [fbsc_pkg::EXT_W-1:0]   half_y,
  input  logic        [fbsc_pkg::EXT_W-1:0]   half_z,
  input  logic                                sphere_s1,
  input  logic        [fbsc_pkg::EXT_W-1:0]   radius_s1,
  output logic                                outside,
  output logic                                crossing
);

  localparam int CW = fbsc_pkg::COORD_W;
  localparam int PW = fbsc_pkg::PROD_W;
  localparam int MW = fbsc_pkg::MAG_W;
  localparam int DW = fbsc_pkg::DIST_W;
  localparam int RW = fbsc_pkg::RAD_W;
  localparam int EW = fbsc_pkg::EDGE_W;
  localparam int FW = fbsc_pkg::FRAC_W;

  logic [CW-1:0] mag_x, mag_y, mag_z;

  // stage 1
  logic signed [PW-1:0] prod_x, prod_y, prod_z;
  logic        [MW-1:0] ext_x, ext_y, ext_z;
  logic signed [CW-1:0] ofs;
  // stage 2
  logic signed [DW-1:0] distance;
  logic        [RW-1:0] rad;
  logic signed [DW-1:0] distance_next;
  logic        [RW-1:0] rad_next;
  // stage 3 sums
  logic signed [EW-1:0] near_edge, far_edge;

  // -2.0 has magnitude 32768, which still fits unsigned
  always_comb begin
    mag_x = plane.nx[CW-1] ? (~plane.nx + CW'(1)) : plane.nx;
    mag_y = plane.ny[CW-1] ? (~plane.ny + CW'(1)) : plane.ny;
    mag_z = plane.nz[CW-1] ? (~plane.nz + CW'(1)) : plane.nz;
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      prod_x <= plane.nx * center_x;
      prod_y <= plane.ny * center_y;
      prod_z <= plane.nz * center_z;
      ext_x  <= mag_x * half_x;
      ext_y  <= mag_y * half_y;
      ext_z  <= mag_z * half_z;
      ofs    <= plane.d;
    end
  end

  always_comb begin
    distance_next = {{(DW-PW){prod_x[PW-1]}}, prod_x}
                  + {{(DW-PW){prod_y[PW-1]}}, prod_y}
                  + {{(DW-PW){prod_z[PW-1]}}, prod_z}
                  + {{(DW-CW-FW){ofs[CW-1]}}, ofs, {FW{1'b0}}};
    if (sphere_s1) begin
      rad_next = {{(RW-fbsc_pkg::EXT_W-FW){1'b0}}, radius_s1, {FW{1'b0}}};
    end else begin
      rad_next = {{(RW-MW){1'b0}}, ext_x} + {{(RW-MW){1'b0}}, ext_y}
               + {{(RW-MW){1'b0}}, ext_z};
    end
  end

  always_ff @(posedge clk) begin
    if (en.en2) begin
      distance <= distance_next;
      rad      <= rad_next;
    end
  end

  always_comb begin
    near_edge = {distance[DW-1], distance} + {{(EW-RW){1'b0}}, rad};
    far_edge  = {distance[DW-1], distance} - {{(EW-RW){1'b0}}, rad};
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      outside  <= near_edge[EW-1];
      crossing <= far_edge[EW-1];
    end
  end

endmodule

// File: hw/rtl/frustum_box_sphere_cull.sv
// Top level of the frustum culler: plane registers, lanes, pipeline control.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------------
//  item     | in  | valid / ready | func, center_xyz, half_xyz, radius, skip
//  result   | out | valid / ready | classification, visible
//  wr_*     | in  | wr_en only    | wr_index selects plane, wr_data 64 bits
//
// Four stages, one word per cycle sustained while result.ready stays high.
// Stage 1 multiplies, stage 2 sums per plane, stage 3 tests signs, stage 4
// merges the six planes into the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stall and nothing is dropped or repeated.
// Reset (rst, synchronous) clears valid bits and all six planes to zero.
`timescale 1ns / 1ps

module frustum_box_sphere_cull (
  input  logic                                clk,
  input  logic                                rst,
  fbsc_item_if.sink                           item,
  fbsc_result_if.source                       result,
  input  logic                                wr_en,
  input  logic [fbsc_pkg::INDEX_W-1:0]        wr_index,
  input  logic [fbsc_pkg::REG_W-1:0]          wr_data
);

  localparam int NP = fbsc_pkg::PLANE_COUNT;

  fbsc_pkg::plane_t    planes [NP];
  fbsc_pkg::stage_en_t en;
  logic                en4;
  logic                v1, v2, v3, v4;
  logic                sphere_s1;
  logic [fbsc_pkg::EXT_W-1:0] radius_s1;
  logic                skip_s1, skip_s2, skip_s3;
  logic [NP-1:0]       outside_p, crossing_p, keep;
  fbsc_pkg::cls_t      cls, cls_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NP; i++) begin
        planes[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        fbsc_pkg::REG_NEAR:   planes[0] <= fbsc_pkg::plane_t'(wr_data);
        fbsc_pkg::REG_FAR:    planes[1] <= fbsc_pkg::plane_t'(wr_data);
        fbsc_pkg::REG_LEFT:   planes[2] <= fbsc_pkg::plane_t'(wr_data);
        fbsc_pkg::REG_RIGHT:  planes[3] <= fbsc_pkg::plane_t'(wr_data);
        fbsc_pkg::REG_TOP:    planes[4] <= fbsc_pkg::plane_t'(wr_data);
        fbsc_pkg::REG_BOTTOM: planes[5] <= fbsc_pkg::plane_t'(wr_data);
        default: ;  // drop writes past the last plane
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en4    = !v4 || result.ready;
    en.en3 = !v3 || en4;
    en.en2 = !v2 || en.en3;
    en.en1 = !v1 || en.en2;
  end

  assign item.ready = en.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.en1) v1 <= item.valid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
      if (en4)    v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      sphere_s1 <= (fbsc_pkg::func_t'(item.func) == fbsc_pkg::FUNC_SPHERE);
      radius_s1 <= item.sphere_radius;
      skip_s1   <= item.skip_depth;
    end
    if (en.en2) skip_s2 <= skip_s1;
    if (en.en3) skip_s3 <= skip_s2;
  end

  for (genvar p = 0; p < NP; p++) begin : g_lane
    fbsc_plane u_plane (
      .clk       (clk),
      .en        (en),
      .plane     (planes[p]),
      .center_x  (item.center_x),
      .center_y  (item.center_y),
      .center_z  (item.center_z),
      .half_x    (item.half_x),
      .half_y    (item.half_y),
      .half_z    (item.half_z),
      .sphere_s1 (sphere_s1),
      .radius_s1 (radius_s1),
      .outside   (outside_p[p]),
      .crossing  (crossing_p[p])
    );
  end

  always_comb begin
    keep = skip_s3 ? ~fbsc_pkg::DEPTH_MASK : {NP{1'b1}};
    if (|(outside_p & keep)) begin
      cls_next = fbsc_pkg::CLS_OUTSIDE;
    end else if (|(crossing_p & keep)) begin
      cls_next = fbsc_pkg::CLS_INTERSECTS;
    end else begin
      cls_next = fbsc_pkg::CLS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) cls <= cls_next;
  end

  assign result.valid          = v4;
  assign result.classification = cls;
  assign result.visible        = (cls != fbsc_pkg::CLS_OUTSIDE);

endmodule

// File: tb/frustum_box_sphere_cull_tb.sv
// Self-checking testbench for the frustum box and sphere culler.
`timescale 1ns / 1ps

module frustum_box_sphere_cull_tb;
  import fbsc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     STALL_CYCLES   = 400;
  localparam int     TAIL_CYCLES    = 10;
  localparam int     ONE_Q14        = 1 << FRAC_W;
  localparam longint Q_SCALE        = longint'(1) << FRAC_W;

  // Indexes past the plane file; writes to them must be ignored
  localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    func_t                     func;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [EXT_W-1:0]          hx, hy, hz;
    logic [EXT_W-1:0]          rad;
    logic                      skip;
  } volume_t;

  typedef struct packed {
    cls_t cls;
    logic visible;
  } verdict_t;

  logic clk;
  logic rst;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [REG_W-1:0]   wr_data;

  fbsc_item_if   item_bus ();
  fbsc_result_if result_bus ();

  frustum_box_sphere_cull dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_bus),
    .result   (result_bus),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  plane_t   plane_copy [PLANE_COUNT];
  volume_t  volumes_pending [$];
  verdict_t verdicts_due [$];
  volume_t  next_vol;
  volume_t  taken_vol;
  verdict_t oldest_due;

  int idle_pct;
  int stall_asked;
  int stall_seen;
  int hold_left;
  int stuck;
  int mismatches;
  int volumes_seen;
  int spheres_seen;
  int reg_writes;
  int class_seen [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cls_t classify_volume(volume_t v);
    longint nx, ny, nz, distance, reach;
    plane_t p;
    bit     outside;
    bit     crossing;
    outside  = 1'b0;
    crossing = 1'b0;
    for (int i = (v.skip ? int'(REG_LEFT) : int'(REG_NEAR)); i < PLANE_COUNT; i++) begin
      p    = plane_copy[i];
      nx   = longint'(p.nx);
      ny   = longint'(p.ny);
      nz   = longint'(p.nz);
      distance = nx * longint'(v.cx) + ny * longint'(v.cy) + nz * longint'(v.cz)
                 + longint'(p.d) * Q_SCALE;
      if (v.func == FUNC_SPHERE) begin
        reach = longint'(v.rad) * Q_SCALE;
      end else begin
        reach = (nx < 0 ? -nx : nx) * longint'(v.hx) + (ny < 0 ? -ny : ny) * longint'(v.hy)
                + (nz < 0 ? -nz : nz) * longint'(v.hz);
      end
      if (distance + reach < 0) outside = 1'b1;
      if (distance - reach < 0) crossing = 1'b1;
    end
    if (outside) return CLS_OUTSIDE;
    if (crossing) return CLS_INTERSECTS;
    return CLS_INSIDE;
  endfunction

  function automatic volume_t make_vol(func_t f, int cx, int cy, int cz,
                                       int hx, int hy, int hz, int rad, bit skip);
    volume_t v;
    v.func = f;
    v.cx   = COORD_W'(cx);
    v.cy   = COORD_W'(cy);
    v.cz   = COORD_W'(cz);
    v.hx   = EXT_W'(hx);
    v.hy   = EXT_W'(hy);
    v.hz   = EXT_W'(hz);
    v.rad  = EXT_W'(rad);
    v.skip = skip;
    return v;
  endfunction

  function automatic volume_t random_volume(int span, int ext);
    volume_t v;
    v.func = func_t'($urandom_range(1));
    v.skip = 1'($urandom_range(1));
    // Mostly near the frustum, now and then anywhere in the field range
    if ($urandom_range(15) == 0) begin
      v.cx  = COORD_W'($urandom);
      v.cy  = COORD_W'($urandom);
      v.cz  = COORD_W'($urandom);
      v.hx  = EXT_W'($urandom);
      v.hy  = EXT_W'($urandom);
      v.hz  = EXT_W'($urandom);
      v.rad = EXT_W'($urandom);
    end else begin
      v.cx  = COORD_W'(int'($urandom_range(2 * span)) - span);
      v.cy  = COORD_W'(int'($urandom_range(2 * span)) - span);
      v.cz  = COORD_W'(int'($urandom_range(2 * span)) - span);
      v.hx  = EXT_W'($urandom_range(ext));
      v.hy  = EXT_W'($urandom_range(ext));
      v.hz  = EXT_W'($urandom_range(ext));
      v.rad = EXT_W'($urandom_range(ext));
    end
    return v;
  endfunction

  function automatic logic [REG_W-1:0] pack_plane(int nx, int ny, int nz, int d);
    plane_t p;
    p.nx = COORD_W'(nx);
    p.ny = COORD_W'(ny);
    p.nz = COORD_W'(nz);
    p.d  = COORD_W'(d);
    return p;
  endfunction

  // Driver: offer the next pending volume, hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (volumes_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_vol = volumes_pending.pop_front();
        item_bus.func          <= next_vol.func;
        item_bus.center_x      <= next_vol.cx;
        item_bus.center_y      <= next_vol.cy;
        item_bus.center_z      <= next_vol.cz;
        item_bus.half_x        <= next_vol.hx;
        item_bus.half_y        <= next_vol.hy;
        item_bus.half_z        <= next_vol.hz;
        item_bus.sphere_radius <= next_vol.rad;
        item_bus.skip_depth    <= next_vol.skip;
        item_bus.valid         <= 1'b1;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      hold_left        <= 0;
    end else if (stall_asked != stall_seen) begin
      stall_seen       <= stall_asked;
      hold_left        <= STALL_CYCLES;
      result_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left        <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: check result words, then predict for accepted volumes
  always @(posedge clk) begin
    if (rst) begin
      stuck <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result word with nothing expected: classification %0d, visible %0d",
                 result_bus.classification, result_bus.visible);
          mismatches++;
        end else begin
          oldest_due = verdicts_due.pop_front();
          if (result_bus.classification !== oldest_due.cls) begin
            $error("classification: expected %0d, got %0d",
                   oldest_due.cls, result_bus.classification);
            mismatches++;
          end
          if (result_bus.visible !== oldest_due.visible) begin
            $error("visible: expected %0d, got %0d", oldest_due.visible, result_bus.visible);
            mismatches++;
          end
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        taken_vol.func = func_t'(item_bus.func);
        taken_vol.cx   = item_bus.center_x;
        taken_vol.cy   = item_bus.center_y;
        taken_vol.cz   = item_bus.center_z;
        taken_vol.hx   = item_bus.half_x;
        taken_vol.hy   = item_bus.half_y;
        taken_vol.hz   = item_bus.half_z;
        taken_vol.rad  = item_bus.sphere_radius;
        taken_vol.skip = item_bus.skip_depth;
        oldest_due.cls     = classify_volume(taken_vol);
        oldest_due.visible = (oldest_due.cls != CLS_OUTSIDE);
        verdicts_due.push_back(oldest_due);
        volumes_seen++;
        if (taken_vol.func == FUNC_SPHERE) spheres_seen++;
        class_seen[int'(oldest_due.cls)]++;
      end
      stuck <= ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
               ? 0 : stuck + 1;
    end
  end

  initial begin
    wait (stuck >= WATCHDOG_LIMIT);
    $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    if (idx < PLANE_COUNT) plane_copy[idx] = val;
    reg_writes++;
  endtask

  task automatic set_planes(input logic [REG_W-1:0] vals [PLANE_COUNT]);
    for (int i = 0; i < PLANE_COUNT; i++) write_reg(INDEX_W'(i), vals[i]);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // Axis-aligned cube of half size w around the origin
  task automatic set_cube(input int w);
    logic [REG_W-1:0] vals [PLANE_COUNT];
    vals[REG_NEAR]   = pack_plane(0, 0, ONE_Q14, w);
    vals[REG_FAR]    = pack_plane(0, 0, -ONE_Q14, w);
    vals[REG_LEFT]   = pack_plane(ONE_Q14, 0, 0, w);
    vals[REG_RIGHT]  = pack_plane(-ONE_Q14, 0, 0, w);
    vals[REG_TOP]    = pack_plane(0, -ONE_Q14, 0, w);
    vals[REG_BOTTOM] = pack_plane(0, ONE_Q14, 0, w);
    set_planes(vals);
  endtask

  // Wait until the block is empty and the sender has nothing left
  task automatic drain();
    while (volumes_pending.size() != 0 || verdicts_due.size() != 0 || item_bus.valid)
      @(negedge clk);
  endtask

  task automatic run_batch(input int count, input int span, input int ext, input int pct);
    @(negedge clk);
    idle_pct = pct;
    for (int k = 0; k < count; k++) volumes_pending.push_back(random_volume(span, ext));
    drain();
  endtask

  initial begin
    logic [REG_W-1:0] vals [PLANE_COUNT];
    rst                    = 1'b1;
    wr_en                  = 1'b0;
    wr_index               = '0;
    wr_data                = '0;
    item_bus.valid         = 1'b0;
    item_bus.func          = 1'b0;
    item_bus.center_x      = '0;
    item_bus.center_y      = '0;
    item_bus.center_z      = '0;
    item_bus.half_x        = '0;
    item_bus.half_y        = '0;
    item_bus.half_z        = '0;
    item_bus.sphere_radius = '0;
    item_bus.skip_depth    = 1'b0;
    result_bus.ready       = 1'b0;
    idle_pct     = 31;
    stall_asked  = 0;
    stall_seen   = 0;
    mismatches   = 0;
    volumes_seen = 0;
    spheres_seen = 0;
    reg_writes   = 0;
    class_seen   = '{0, 0, 0};
    for (int i = 0; i < PLANE_COUNT; i++) plane_copy[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Planes straight out of reset: boxes are inside, the sphere with a radius intersects
    @(negedge clk);
    volumes_pending.push_back(make_vol(FUNC_BOX, -32768, 32767, 0, 32767, 0, 32767, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 32767, -32768, -32768, 0, 0, 0, 32767, 1));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Directed corners against a cube of half size 1000
    set_cube(1000);
    @(negedge clk);
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 0, 500, 500, 500, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 0, 1500, 1500, 1500, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 3000, 0, 0, 100, 100, 100, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 1500, 0, 0, 600, 600, 600, 0, 0));
    // Point spheres: inside, on the plane, just past it
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 1000, 0, 0, 0, 0, 0, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 1001, 0, 0, 0, 0, 0, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 32767, 0));
    // Beyond the far or near plane, with and without depth planes
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 0, 0, 5000, 0, 0, 0, 100, 1));
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 0, 0, 5000, 0, 0, 0, 100, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 5000, 100, 100, 100, 0, 1));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, -5000, 100, 100, 100, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, -32768, -32768, -32768, 32767, 32767, 32767,
                                       0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 32767, 32767, 32767, 32767, 32767, 32767,
                                       0, 0));
    // Fields of the other volume kind carry junk and must not matter
    volumes_pending.push_back(make_vol(FUNC_SPHERE, 0, 0, 0, 32767, 32767, 32767, 0, 0));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 0, 0, 0, 0, 32767, 0));
    volumes_pending.push_back(make_vol(FUNC_SPHERE, -32768, 32767, 0, 0, 0, 0, 32767, 1));
    volumes_pending.push_back(make_vol(FUNC_BOX, 0, 0, 0, 32767, 0, 0, 0, 1));
    drain();

    // Long hold-off on the result side while volumes keep coming
    @(negedge clk);
    stall_asked++;
    run_batch(300, 2500, 1500, 31);

    // Wide cube, no idling on either side
    set_cube(20000);
    run_batch(200, 30000, 20000, 0);

    // Tilted planes that mostly contain the origin
    for (int i = 0; i < PLANE_COUNT; i++)
      vals[i] = pack_plane(int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                           int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                           int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                           int'($urandom_range(3000)) - 500);
    set_planes(vals);
    run_batch(300, 4000, 2000, 31);

    // Extreme plane words, and writes past the plane file
    write_reg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    vals[REG_NEAR]   = 64'h8000_8000_8000_8000;
    vals[REG_FAR]    = 64'hFFFF_FFFF_FFFF_FFFF;
    vals[REG_LEFT]   = 64'h7FFF_7FFF_7FFF_7FFF;
    vals[REG_RIGHT]  = '0;
    vals[REG_TOP]    = pack_plane(32767, 0, -32768, 32767);
    vals[REG_BOTTOM] = pack_plane(-32768, ONE_Q14, 0, -32768);
    set_planes(vals);
    run_batch(150, 32767, 32767, 31);

    // Fully random plane words
    for (int i = 0; i < PLANE_COUNT; i++) vals[i] = {$urandom, $urandom};
    set_planes(vals);
    run_batch(150, 32767, 32767, 31);

    // Another tilted frustum, offsets spread wider
    for (int i = 0; i < PLANE_COUNT; i++)
      vals[i] = pack_plane(int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                           int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                           int'($urandom_range(2 * ONE_Q14)) - ONE_Q14,
                           int'($urandom_range(8000)) - 1000);
    set_planes(vals);
    run_batch(200, 6000, 3000, 31);

    // Let any stray word surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $error("%0d result words never arrived", verdicts_due.size());
      mismatches += verdicts_due.size();
    end

    $display("Covered %0d volumes (%0d spheres) over %0d register writes",
             volumes_seen, spheres_seen, reg_writes);
    $display("Verdicts: %0d outside, %0d intersecting, %0d inside; %0d mismatches",
             class_seen[CLS_OUTSIDE], class_seen[CLS_INTERSECTS], class_seen[CLS_INSIDE],
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/fbsc_pkg.sv
hw/rtl/fbsc_item_if.sv
hw/rtl/fbsc_result_if.sv
hw/rtl/fbsc_plane.sv
hw/rtl/frustum_box_sphere_cull.sv
tb/frustum_box_sphere_cull_tb.sv
